### rtl/wsfla_pkg.sv
package wsfla_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NONE_FREE  = 2'd1;
  localparam logic [1:0] ST_NO_ACTIVE  = 2'd2;
  localparam logic [1:0] ST_NOT_ACTIVE = 2'd3;

  // Command codes of an input transaction
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_ALLOC,
    S_REL_HEAD,
    S_WALK,
    S_UNLINK,
    S_PUSH,
    S_FINISH
  } state_e;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_ALLOC,
    OP_REL_HEAD,
    OP_WALK_INIT,
    OP_WALK_STEP,
    OP_WALK_HIT,
    OP_UNLINK,
    OP_PUSH,
    OP_RES_NONE_FREE,
    OP_RES_NO_ACTIVE,
    OP_RES_NOT_ACTIVE,
    OP_PUBLISH
  } op_e;

  // Link memory read address source
  typedef enum logic [1:0] {
    RD_FREE_HEAD,
    RD_ACTIVE_HEAD,
    RD_WORD
  } rd_sel_e;

  typedef struct packed {
    op_e     op;
    logic    rd_en;
    rd_sel_e rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd_release;
    logic free_empty;
    logic active_empty;
    logic head_match;
    logic cur_is_slot;
    logic cur_match;
    logic steps_last;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/wsfla_ctrl.sv
module wsfla_ctrl
  import wsfla_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.cmd_release) begin
          state_d = sts_i.free_empty ? S_FINISH : S_ALLOC;
        end else if (sts_i.active_empty) begin
          state_d = S_FINISH;
        end else if (sts_i.head_match) begin
          state_d = S_REL_HEAD;
        end else begin
          state_d = S_WALK;
        end
      end
      S_ALLOC:    state_d = S_FINISH;
      S_REL_HEAD: state_d = S_FINISH;
      S_WALK: begin
        if (!sts_i.cur_is_slot) begin
          state_d = S_FINISH;
        end else if (sts_i.cur_match) begin
          state_d = S_UNLINK;
        end else if (sts_i.steps_last) begin
          state_d = S_FINISH;
        end
      end
      S_UNLINK: state_d = S_PUSH;
      S_PUSH:   state_d = S_FINISH;
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o.op     = OP_NONE;
    cmd_o.rd_en  = 1'b0;
    cmd_o.rd_sel = RD_WORD;
    in_stall_o   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) cmd_o.op = OP_CAPTURE;
      end
      S_DECIDE: begin
        if (!sts_i.cmd_release) begin
          if (sts_i.free_empty) begin
            cmd_o.op = OP_RES_NONE_FREE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_FREE_HEAD;
          end
        end else if (sts_i.active_empty) begin
          cmd_o.op = OP_RES_NO_ACTIVE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_ACTIVE_HEAD;
          if (!sts_i.head_match) cmd_o.op = OP_WALK_INIT;
        end
      end
      S_ALLOC:    cmd_o.op = OP_ALLOC;
      S_REL_HEAD: cmd_o.op = OP_REL_HEAD;
      S_WALK: begin
        if (!sts_i.cur_is_slot) begin
          cmd_o.op = OP_RES_NOT_ACTIVE;
        end else if (sts_i.cur_match) begin
          cmd_o.op    = OP_WALK_HIT;
          cmd_o.rd_en = 1'b1;
        end else if (sts_i.steps_last) begin
          cmd_o.op = OP_RES_NOT_ACTIVE;
        end else begin
          cmd_o.op    = OP_WALK_STEP;
          cmd_o.rd_en = 1'b1;
        end
      end
      S_UNLINK: cmd_o.op = OP_UNLINK;
      S_PUSH:   cmd_o.op = OP_PUSH;
      S_FINISH: begin
        if (sts_i.out_free) cmd_o.op = OP_PUBLISH;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

### rtl/wsfla_dp.sv
module wsfla_dp
  import wsfla_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       command_i,
  input  logic [4:0] slot_number_i,
  input  dp_cmd_t    cmd_i,
  output dp_sts_t    sts_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [1:0] status_o,
  output logic [4:0] granted_slot_o
);

  localparam int unsigned SW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned LW = $clog2(POOL_SIZE + 1);
  localparam int unsigned CW = (LW > 5) ? LW : 5;
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SIZE);

  // Link memory, one valid bit per entry; an unwritten entry i reads as i+1
  logic [LW-1:0]        link_mem_q [POOL_SIZE];
  logic [POOL_SIZE-1:0] link_vld_q;
  logic [LW-1:0]        rd_data_q;
  logic                 rd_vld_q;
  logic [SW-1:0]        rd_addr_q;

  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [LW-1:0] wr_data;
  logic [SW-1:0] rd_addr;
  logic [LW-1:0] rd_word;

  logic [LW-1:0] free_head_q, free_head_d;
  logic [LW-1:0] active_head_q, active_head_d;
  logic          cmd_q, cmd_d;
  logic [4:0]    want_q, want_d;
  logic [SW-1:0] prev_q, prev_d;
  logic [SW-1:0] cur_q, cur_d;
  logic [SW-1:0] steps_q, steps_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [4:0]    res_slot_q, res_slot_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [4:0]    out_slot_q, out_slot_d;

  // Resolve the word read last cycle
  assign rd_word = rd_vld_q ? rd_data_q : (LW'(rd_addr_q) + LW'(1));

  // Select the read address
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_FREE_HEAD:   rd_addr = free_head_q[SW-1:0];
      RD_ACTIVE_HEAD: rd_addr = active_head_q[SW-1:0];
      RD_WORD:        rd_addr = rd_word[SW-1:0];
      default:        rd_addr = rd_word[SW-1:0];
    endcase
  end

  // Next values of the list registers and memory write
  always_comb begin
    free_head_d   = free_head_q;
    active_head_d = active_head_q;
    cmd_d         = cmd_q;
    want_d        = want_q;
    prev_d        = prev_q;
    cur_d         = cur_q;
    steps_d       = steps_q;
    res_status_d  = res_status_q;
    res_slot_d    = res_slot_q;
    out_status_d  = out_status_q;
    out_slot_d    = out_slot_q;
    wr_en         = 1'b0;
    wr_addr       = prev_q;
    wr_data       = rd_word;
    case (cmd_i.op)
      OP_CAPTURE: begin
        cmd_d  = command_i;
        want_d = slot_number_i;
      end
      OP_ALLOC: begin
        free_head_d   = rd_word;
        wr_en         = 1'b1;
        wr_addr       = free_head_q[SW-1:0];
        wr_data       = active_head_q;
        active_head_d = free_head_q;
        res_status_d  = ST_OK;
        res_slot_d    = 5'(free_head_q[SW-1:0]);
      end
      OP_REL_HEAD: begin
        active_head_d = rd_word;
        wr_en         = 1'b1;
        wr_addr       = active_head_q[SW-1:0];
        wr_data       = free_head_q;
        free_head_d   = active_head_q;
        res_status_d  = ST_OK;
        res_slot_d    = 5'(active_head_q[SW-1:0]);
      end
      OP_WALK_INIT: begin
        prev_d  = active_head_q[SW-1:0];
        steps_d = '0;
      end
      OP_WALK_STEP: begin
        prev_d  = rd_word[SW-1:0];
        steps_d = steps_q + SW'(1);
      end
      OP_WALK_HIT: cur_d = rd_word[SW-1:0];
      OP_UNLINK: begin
        // Bridge the predecessor over the slot being released
        wr_en   = 1'b1;
        wr_addr = prev_q;
        wr_data = rd_word;
      end
      OP_PUSH: begin
        wr_en        = 1'b1;
        wr_addr      = cur_q;
        wr_data      = free_head_q;
        free_head_d  = LW'(cur_q);
        res_status_d = ST_OK;
        res_slot_d   = 5'(cur_q);
      end
      OP_RES_NONE_FREE: begin
        res_status_d = ST_NONE_FREE;
        res_slot_d   = '0;
      end
      OP_RES_NO_ACTIVE: begin
        res_status_d = ST_NO_ACTIVE;
        res_slot_d   = '0;
      end
      OP_RES_NOT_ACTIVE: begin
        res_status_d = ST_NOT_ACTIVE;
        res_slot_d   = '0;
      end
      OP_PUBLISH: begin
        out_status_d = res_status_q;
        out_slot_d   = res_slot_q;
      end
      default: ;
    endcase
  end

  // Output register: load on publish, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.op == OP_PUBLISH) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Link memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) link_mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rd_data_q <= link_mem_q[rd_addr];
  end

  // Valid bits and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (wr_en) link_vld_q[wr_addr] <= 1'b1;
      if (cmd_i.rd_en) begin
        rd_vld_q  <= link_vld_q[rd_addr];
        rd_addr_q <= rd_addr;
      end
    end
  end

  // List heads and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q   <= '0;
      active_head_q <= NULL_LINK;
      cmd_q         <= CMD_ALLOC;
      out_valid_q   <= 1'b0;
    end else begin
      free_head_q   <= free_head_d;
      active_head_q <= active_head_d;
      cmd_q         <= cmd_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    want_q       <= want_d;
    prev_q       <= prev_d;
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  // Status towards the controller
  assign sts_o.cmd_release  = (cmd_q == CMD_RELEASE);
  assign sts_o.free_empty   = !(free_head_q < NULL_LINK);
  assign sts_o.active_empty = !(active_head_q < NULL_LINK);
  assign sts_o.head_match   = (CW'(active_head_q) == CW'(want_q));
  assign sts_o.cur_is_slot  = (rd_word < NULL_LINK);
  assign sts_o.cur_match    = (CW'(rd_word) == CW'(want_q));
  assign sts_o.steps_last   = (steps_q == SW'(POOL_SIZE - 1));
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign granted_slot_o = out_slot_q;

endmodule

### rtl/watch_slot_free_list_allocator_top.sv
// Slot pool allocator with a free list and an active list in one link memory.
//
// Input channel (in_valid_i / in_stall_o): command_i 0 allocates the head of
// the free list and moves it to the head of the active list; command_i 1
// releases slot_number_i, searching the active list from its head.
// Output channel (out_valid_o / out_stall_i): one transaction per input
// transaction, status_o (ok, none free, no active, not active) and
// granted_slot_o (the slot on ok, else 0).
// Steps: DECIDE tests the captured command; a failure that needs no search
// goes straight to FINISH, an allocate passes through ALLOC and a release of
// the active head through REL_HEAD. A release further down the list walks
// it in WALK, then unlinks the slot in UNLINK and pushes it in PUSH; FINISH
// publishes the result. The search reads one link per cycle from the link
// memory, and a search that reaches the end of the list ends as not active.
// One transaction is processed at a time; the next one is taken once the
// result sits in the output register, even while that result is stalled.
// A new result waits in the result register while out_stall_i holds the
// previous one, which delays its publication.
// Reset: the free list holds every slot in order, the active list is empty;
// per-entry valid bits make the link memory read its reset value at once.
module watch_slot_free_list_allocator_top
  import wsfla_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [4:0] slot_number_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [4:0] granted_slot_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  wsfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  wsfla_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .command_i      (command_i),
    .slot_number_i  (slot_number_i),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o)
  );

  // One transaction in flight: stall straight after acceptance
  a_single_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted on consecutive cycles");

  // Never overwrite a result that is still stalled
  a_publish_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.op == OP_PUBLISH) |-> (!out_valid_o || !out_stall_i))
    else $error("result published over a stalled result");

  // Failures carry slot zero
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (granted_slot_o == 5'd0))
    else $error("failed transaction reports a slot");

  // Granted slot lies inside the pool
  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_OK)) |->
      ((POOL_SIZE >= 32) || (32'(granted_slot_o) < POOL_SIZE)))
    else $error("granted slot outside the pool");

endmodule
